[hw/rtl/dns_response_answer_parser_core_assert.svh]
// Assertion macros shared by the parser core.
`ifndef DNS_RESPONSE_ANSWER_PARSER_CORE_ASSERT_SVH
`define DNS_RESPONSE_ANSWER_PARSER_CORE_ASSERT_SVH

// Checked only while out of reset
`define DRAP_ASSERT_ON(name, prop, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked at every edge, reset included
`define DRAP_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge aclk) prop) else $error(msg);

`endif

[hw/rtl/drap_pkg.sv]
package drap_pkg;

    // Message layout
    localparam logic [15:0] HEADER_BYTES    = 16'd12;
    localparam logic [15:0] QTAIL_BYTES     = 16'd4;
    localparam logic [15:0] ANS_FIXED_BYTES = 16'd12;
    localparam logic [15:0] ADDRESS_BYTES   = 16'd16;
    localparam logic [15:0] HDR_ANCOUNT_HI  = 16'd6;
    localparam logic [15:0] HDR_ANCOUNT_LO  = 16'd7;
    localparam logic [15:0] ANS_TYPE_HI     = 16'd2;
    localparam logic [15:0] ANS_TYPE_LO     = 16'd3;
    localparam logic [15:0] ANS_RDLEN_HI    = 16'd10;
    localparam logic [15:0] ANS_RDLEN_LO    = 16'd11;
    localparam logic [15:0] TYPE_AAAA       = 16'd28;

    // Record kinds
    localparam logic KIND_ANSWER  = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef enum logic [3:0] {
        PH_HEADER,
        PH_QLEN,
        PH_QLABEL,
        PH_QTAIL,
        PH_ANSFIX,
        PH_RDATA,
        PH_DONE
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_message;
    } in_item_t;

    typedef struct packed {
        logic        record_kind;
        logic [15:0] answer_index;
        logic [15:0] record_type;
        logic [15:0] rdata_length;
        logic        is_ipv6;
        logic [63:0] address_high;
        logic [63:0] address_low;
        logic [15:0] answer_count;
        logic [15:0] answers_parsed;
        logic        parse_complete;
        logic        last_of_run;
    } out_item_t;

    // Records produced by one accepted byte
    typedef struct packed {
        logic      ans_vld;
        logic      sum_vld;
        out_item_t ans;
        out_item_t sum;
    } emit_t;

endpackage

[hw/rtl/drap_parser.sv]
module drap_parser (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_fire,
    input  drap_pkg::in_item_t in_item,
    output drap_pkg::emit_t  emit
);
    import drap_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [15:0] cnt_reg, cnt_next;
    logic [15:0] anc_reg, anc_next;
    logic [15:0] fin_reg, fin_next;
    logic [15:0] type_reg, type_next;
    logic [15:0] len_reg, len_next;
    logic [1:0][63:0] addr_reg, addr_next;

    logic [7:0]  b;
    logic [15:0] cnt_inc;
    logic [15:0] fin_inc;
    logic [2:0]  lane;
    logic        do_emit;
    logic        v6;

    assign b       = in_item.data_byte;
    assign cnt_inc = cnt_reg + 16'd1;
    assign fin_inc = fin_reg + 16'd1;
    assign lane    = 3'd7 - cnt_reg[2:0];

    // Next state and records for the current byte
    always_comb begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        anc_next   = anc_reg;
        fin_next   = fin_reg;
        type_next  = type_reg;
        len_next   = len_reg;
        addr_next  = addr_reg;
        do_emit    = 1'b0;
        v6         = 1'b0;
        emit       = '0;

        case (phase_reg)
            PH_HEADER: begin
                if (cnt_reg == HDR_ANCOUNT_HI) begin
                    anc_next = {b, 8'h00};
                end else if (cnt_reg == HDR_ANCOUNT_LO) begin
                    anc_next = anc_reg | {8'h00, b};
                end
                if (cnt_inc >= HEADER_BYTES) begin
                    cnt_next   = '0;
                    phase_next = PH_QLEN;
                end else begin
                    cnt_next = cnt_inc;
                end
            end
            PH_QLEN: begin
                if (b == 8'h00) begin
                    cnt_next   = '0;
                    phase_next = PH_QTAIL;
                end else begin
                    cnt_next   = {8'h00, b};
                    phase_next = PH_QLABEL;
                end
            end
            PH_QLABEL: begin
                cnt_next = cnt_reg - 16'd1;
                if (cnt_next == 16'd0) begin
                    phase_next = PH_QLEN;
                end
            end
            PH_QTAIL: begin
                if (cnt_inc >= QTAIL_BYTES) begin
                    cnt_next   = '0;
                    phase_next = (anc_reg != 16'd0) ? PH_ANSFIX : PH_DONE;
                end else begin
                    cnt_next = cnt_inc;
                end
            end
            PH_ANSFIX: begin
                if (cnt_reg == ANS_TYPE_HI) begin
                    type_next = {b, 8'h00};
                end else if (cnt_reg == ANS_TYPE_LO) begin
                    type_next = type_reg | {8'h00, b};
                end else if (cnt_reg == ANS_RDLEN_HI) begin
                    len_next = {b, 8'h00};
                end else if (cnt_reg == ANS_RDLEN_LO) begin
                    len_next = len_reg | {8'h00, b};
                end
                if (cnt_inc >= ANS_FIXED_BYTES) begin
                    cnt_next = '0;
                    if (len_next == 16'd0) begin
                        do_emit = 1'b1;
                    end else begin
                        phase_next = PH_RDATA;
                    end
                end else begin
                    cnt_next = cnt_inc;
                end
            end
            PH_RDATA: begin
                // keep the first 16 address bytes, first byte on top
                if (type_reg == TYPE_AAAA && cnt_reg < ADDRESS_BYTES) begin
                    addr_next[cnt_reg[3]][{lane, 3'b000} +: 8] =
                        addr_reg[cnt_reg[3]][{lane, 3'b000} +: 8] | b;
                end
                cnt_next = cnt_inc;
                if (cnt_inc == len_reg) begin
                    do_emit = 1'b1;
                end
            end
            default: begin
            end
        endcase

        // Answer record
        if (do_emit) begin
            v6                      = (type_next == TYPE_AAAA);
            emit.ans.record_kind    = KIND_ANSWER;
            emit.ans.answer_index   = fin_reg;
            emit.ans.record_type    = type_next;
            emit.ans.rdata_length   = len_next;
            emit.ans.is_ipv6        = v6;
            emit.ans.address_high   = v6 ? addr_next[0] : 64'd0;
            emit.ans.address_low    = v6 ? addr_next[1] : 64'd0;
            emit.ans.last_of_run    = !in_item.end_of_message;
            fin_next   = fin_inc;
            addr_next  = '0;
            cnt_next   = '0;
            phase_next = (fin_inc == anc_next) ? PH_DONE : PH_ANSFIX;
        end

        // Summary record, then back to the start of a message
        if (in_item.end_of_message) begin
            emit.sum.record_kind    = KIND_SUMMARY;
            emit.sum.answer_count   = anc_next;
            emit.sum.answers_parsed = fin_next;
            emit.sum.parse_complete = (phase_next == PH_DONE);
            emit.sum.last_of_run    = 1'b1;
            phase_next = PH_HEADER;
            cnt_next   = '0;
            anc_next   = '0;
            fin_next   = '0;
            type_next  = '0;
            len_next   = '0;
            addr_next  = '0;
        end

        emit.ans_vld = in_fire && do_emit;
        emit.sum_vld = in_fire && in_item.end_of_message;
    end

    // Parser state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HEADER;
            cnt_reg   <= '0;
            anc_reg   <= '0;
            fin_reg   <= '0;
            type_reg  <= '0;
            len_reg   <= '0;
            addr_reg  <= '0;
        end else if (in_fire) begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            anc_reg   <= anc_next;
            fin_reg   <= fin_next;
            type_reg  <= type_next;
            len_reg   <= len_next;
            addr_reg  <= addr_next;
        end
    end

endmodule

[hw/rtl/drap_result_fifo.sv]
module drap_result_fifo (
    input  logic                aclk,
    input  logic                aresetn,
    input  drap_pkg::emit_t     emit,
    output logic                room,
    output logic                m_valid,
    input  logic                m_ready,
    output drap_pkg::out_item_t m_data
);
    import drap_pkg::*;

    out_item_t   mem [4];
    logic [1:0]  wr_ptr_reg, wr_ptr_next;
    logic [1:0]  rd_ptr_reg, rd_ptr_next;
    logic [2:0]  count_reg, count_next;
    logic [1:0]  sum_addr;
    logic        pop;

    assign pop      = m_valid && m_ready;
    assign sum_addr = emit.ans_vld ? wr_ptr_reg + 2'd1 : wr_ptr_reg;

    // Room for the two records one byte can cause
    assign room    = (count_reg <= 3'd2);
    assign m_valid = (count_reg != 3'd0);
    assign m_data  = mem[rd_ptr_reg];

    // Pointer and fill bookkeeping
    always_comb begin
        wr_ptr_next = wr_ptr_reg + {1'b0, emit.ans_vld} + {1'b0, emit.sum_vld};
        rd_ptr_next = rd_ptr_reg + {1'b0, pop};
        count_next  = count_reg + {2'b00, emit.ans_vld} + {2'b00, emit.sum_vld}
                      - {2'b00, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Record storage
    always_ff @(posedge aclk) begin
        if (emit.ans_vld) begin
            mem[wr_ptr_reg] <= emit.ans;
        end
        if (emit.sum_vld) begin
            mem[sum_addr] <= emit.sum;
        end
    end

endmodule

[hw/rtl/dns_response_answer_parser_core.sv]
// Channel | Ports                       | Item
// input   | s_valid s_ready s_data      | one message byte, end marker
// output  | m_valid m_ready m_data      | answer record or summary record
//
// Each byte is parsed in the cycle it is accepted; its records are in the
// result queue in the following cycle. One byte per cycle is sustained
// while the queue has room; a byte that completes an answer and ends the
// message queues two records. s_ready drops only when the four-entry result
// queue has fewer than two free slots. Reset (aresetn low, synchronous)
// empties the queue and returns the parser to the header of a new message.
`include "dns_response_answer_parser_core_assert.svh"

module dns_response_answer_parser_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  drap_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output drap_pkg::out_item_t m_data
);
    import drap_pkg::*;

    emit_t emit;
    logic  in_fire;

    assign in_fire = s_valid && s_ready;

    drap_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_fire (in_fire),
        .in_item (s_data),
        .emit    (emit)
    );

    drap_result_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .emit    (emit),
        .room    (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // Checks
    `DRAP_ASSERT_ON(a_eom_gives_summary, in_fire && s_data.end_of_message |-> emit.sum_vld, "end byte without summary")
    `DRAP_ASSERT_ON(a_emit_needs_accept, emit.ans_vld || emit.sum_vld |-> in_fire, "record without accepted byte")
    `DRAP_ASSERT_ON(a_summary_shows, emit.sum_vld |=> m_valid, "summary not queued")
    `DRAP_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_valid, "queue not empty after reset")

endmodule
